// ----- sv/rotated_ellipse_point_eval_unit_assert.svh -----
// Assertion macros for the rotated ellipse point evaluator.
// Used by the top level only; no other dependencies.
`ifndef ROTATED_ELLIPSE_POINT_EVAL_UNIT_ASSERT_SVH
`define ROTATED_ELLIPSE_POINT_EVAL_UNIT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define REEP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");
// next-cycle implication
`define REEP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");
`else
`define REEP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define REEP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/reep_pkg.sv -----
// Shared constants for the rotated ellipse evaluator: CORDIC widths,
// arctangent table and configuration register indexes. No dependencies.
package reep_pkg;

    localparam int DEF_ANGLE_BITS    = 16;
    localparam int DEF_COORD_BITS    = 32;
    localparam int DEF_CORDIC_STAGES = 16;

    localparam int MAX_STAGES = 24;
    localparam int TURN_BITS  = 32;
    localparam int XW         = 34;   // CORDIC x/y, Q2.30 plus headroom
    localparam int ZW         = 33;   // residual angle, signed turn fraction

    localparam logic signed [XW-1:0] CORDIC_X0 = 34'sd652032874;

    // arctan(2^-i) in units of 2^-32 turn
    localparam logic [TURN_BITS-1:0] ATAN_TURNS [MAX_STAGES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41721,     32'd20860,
        32'd10430,     32'd5215,      32'd2607,      32'd1303,
        32'd651,       32'd325,       32'd162,       32'd81
    };

    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CENTER_X   = 3'd0,
        CFG_CENTER_Y   = 3'd1,
        CFG_RADIUS_ONE = 3'd2,
        CFG_RADIUS_TWO = 3'd3,
        CFG_TILT_ANGLE = 3'd4
    } cfg_idx_t;

endpackage

// ----- sv/reep_cordic_cell.sv -----
// One rotation-mode CORDIC micro-rotation with its output registers.
// Depends on reep_pkg for widths and the arctangent table.
module reep_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                         aclk,
    input  logic                         adv,
    input  logic signed [reep_pkg::XW-1:0] x_in,
    input  logic signed [reep_pkg::XW-1:0] y_in,
    input  logic signed [reep_pkg::ZW-1:0] z_in,
    output logic signed [reep_pkg::XW-1:0] x_out,
    output logic signed [reep_pkg::XW-1:0] y_out,
    output logic signed [reep_pkg::ZW-1:0] z_out
);
    import reep_pkg::*;

    localparam logic signed [ZW-1:0] ATAN_STEP = {1'b0, ATAN_TURNS[STAGE]};

    logic signed [XW-1:0] x_reg, x_next, y_reg, y_next, dx, dy;
    logic signed [ZW-1:0] z_reg, z_next;

    always_comb begin
        dx = y_in >>> STAGE;
        dy = x_in >>> STAGE;
        if (!z_in[ZW-1]) begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN_STEP;
        end else begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN_STEP;
        end
    end

    // hold while the output side stalls
    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// ----- sv/rotated_ellipse_point_eval_unit.sv -----
// Top level of the rotated ellipse point/derivative evaluator.
// Depends on reep_pkg, reep_cordic_cell and rotated_ellipse_point_eval_unit_assert.svh.
//
// Usage:
//   Input stream (s_*): one transfer per curve parameter. s_tdata carries
//   param_angle, s_tuser carries operation (0 point, 1 derivative).
//   Output stream (m_*): one transfer per input. m_tdata carries out_x then
//   out_y (signed Q16.16, saturated); m_tuser carries curve_valid.
//   Config channel (cfg_*): always ready; index selects center_x, center_y,
//   radius_one, radius_two, tilt_angle. Unknown indexes are dropped. Write
//   only while no item is in flight.
// Pipeline: one input register, one cell per CORDIC stage, five
//   fold/multiply/round/sum stages (P0 to P4), one output register.
// Throughput: one item per cycle unless stalled. Two lanes of CORDIC cells
//   (parameter and tilt) run side by side; each cell feeds the next on advance.
// Stall: the whole pipe advances only when the output register is empty or
//   being taken; s_tready follows that, so nothing is lost or repeated.
// Reset: aresetn (synchronous, active low) empties the pipe and clears all
//   configuration registers to zero.
module rotated_ellipse_point_eval_unit #(
    parameter int ANGLE_BITS    = reep_pkg::DEF_ANGLE_BITS,
    parameter int COORD_BITS    = reep_pkg::DEF_COORD_BITS,
    parameter int CORDIC_STAGES = reep_pkg::DEF_CORDIC_STAGES
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: [ANGLE_BITS-1:0] param_angle, zero padded to bytes
    input  logic [((ANGLE_BITS+7)/8)*8-1:0]     s_tdata,
    // s_tuser: [0] operation
    input  logic [0:0]                          s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // m_tdata: [COORD_BITS-1:0] out_x, [2*COORD_BITS-1:COORD_BITS] out_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0]   m_tdata,
    // m_tuser: [0] curve_valid
    output logic [0:0]                          m_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [reep_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [((COORD_BITS > ANGLE_BITS) ? COORD_BITS : ANGLE_BITS)-1:0] cfg_data
);
    import reep_pkg::*;

    localparam int N     = CORDIC_STAGES;
    localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;
    localparam int P1W   = COORD_BITS + XW;     // radius * sin/cos
    localparam int UW    = COORD_BITS + 2;      // unrotated vector component
    localparam int P3W   = UW + XW;             // component * sin/cos of tilt
    localparam int SW    = COORD_BITS + 3;      // rotated sum plus center

    localparam logic signed [P1W-1:0] HALF1 = P1W'(64'sd1 <<< 29);
    localparam logic signed [P3W-1:0] HALF3 = P3W'(64'sd1 <<< 29);
    localparam logic signed [SW-1:0]  SAT_HI = SW'((64'sd1 <<< (COORD_BITS-1)) - 64'sd1);
    localparam logic signed [SW-1:0]  SAT_LO = -SAT_HI - SW'(1);
    localparam logic signed [XW-1:0]  CORDIC_LIMIT = XW'(64'sd1 <<< 31);

    // ---------------- configuration registers ----------------
    logic signed [COORD_BITS-1:0] center_x_reg, center_y_reg;
    logic [COORD_BITS-2:0]        radius_one_reg, radius_two_reg;
    logic [ANGLE_BITS-1:0]        tilt_angle_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            radius_one_reg <= '0;
            radius_two_reg <= '0;
            tilt_angle_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CENTER_X:   center_x_reg   <= cfg_data[COORD_BITS-1:0];
                CFG_CENTER_Y:   center_y_reg   <= cfg_data[COORD_BITS-1:0];
                CFG_RADIUS_ONE: radius_one_reg <= cfg_data[COORD_BITS-2:0];
                CFG_RADIUS_TWO: radius_two_reg <= cfg_data[COORD_BITS-2:0];
                CFG_TILT_ANGLE: tilt_angle_reg <= cfg_data[ANGLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    // every stage advances together; the pipe holds only when the output register
    // is full while the receiver stalls
    logic adv;
    logic m_tvalid_reg;
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // ---------------- quadrant fold ----------------
    // widen to a 32-bit turn fraction; quadrants 1 and 2 get a half turn
    // added and the CORDIC result negated later
    logic [TURN_BITS-1:0] t_turn, a_turn, t_fold, a_fold;
    logic                 t_flip, a_flip;

    always_comb begin
        t_turn = {s_tdata[ANGLE_BITS-1:0], {(TURN_BITS-ANGLE_BITS){1'b0}}};
        a_turn = {tilt_angle_reg, {(TURN_BITS-ANGLE_BITS){1'b0}}};
        t_flip = t_turn[TURN_BITS-1] ^ t_turn[TURN_BITS-2];
        a_flip = a_turn[TURN_BITS-1] ^ a_turn[TURN_BITS-2];
        t_fold = {t_turn[TURN_BITS-1] ^ t_flip, t_turn[TURN_BITS-2:0]};
        a_fold = {a_turn[TURN_BITS-1] ^ a_flip, a_turn[TURN_BITS-2:0]};
    end

    // sideband that travels beside the cells: index 0 is the input register,
    // index k+1 sits beside cell k's output
    logic vld_reg    [0:N];
    logic op_reg     [0:N];
    logic flip_t_reg [0:N];
    logic flip_a_reg [0:N];
    logic signed [ZW-1:0] z_t0_reg, z_a0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= N; k++) vld_reg[k] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= s_tvalid;
            for (int k = 0; k < N; k++) vld_reg[k+1] <= vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            op_reg[0]     <= s_tuser[0];
            flip_t_reg[0] <= t_flip;
            flip_a_reg[0] <= a_flip;
            z_t0_reg      <= {t_fold[TURN_BITS-1], t_fold};
            z_a0_reg      <= {a_fold[TURN_BITS-1], a_fold};
            for (int k = 0; k < N; k++) begin
                op_reg[k+1]     <= op_reg[k];
                flip_t_reg[k+1] <= flip_t_reg[k];
                flip_a_reg[k+1] <= flip_a_reg[k];
            end
        end
    end

    // ---------------- CORDIC chain, two lanes ----------------
    logic signed [XW-1:0] xt_w [0:N];
    logic signed [XW-1:0] yt_w [0:N];
    logic signed [ZW-1:0] zt_w [0:N];
    logic signed [XW-1:0] xa_w [0:N];
    logic signed [XW-1:0] ya_w [0:N];
    logic signed [ZW-1:0] za_w [0:N];

    assign xt_w[0] = CORDIC_X0;
    assign yt_w[0] = '0;
    assign zt_w[0] = z_t0_reg;
    assign xa_w[0] = CORDIC_X0;
    assign ya_w[0] = '0;
    assign za_w[0] = z_a0_reg;

    for (genvar k = 0; k < N; k++) begin : g_cell
        reep_cordic_cell #(.STAGE(k)) u_cell_t (
            .aclk  (aclk),
            .adv   (adv),
            .x_in  (xt_w[k]),
            .y_in  (yt_w[k]),
            .z_in  (zt_w[k]),
            .x_out (xt_w[k+1]),
            .y_out (yt_w[k+1]),
            .z_out (zt_w[k+1])
        );
        reep_cordic_cell #(.STAGE(k)) u_cell_a (
            .aclk  (aclk),
            .adv   (adv),
            .x_in  (xa_w[k]),
            .y_in  (ya_w[k]),
            .z_in  (za_w[k]),
            .x_out (xa_w[k+1]),
            .y_out (ya_w[k+1]),
            .z_out (za_w[k+1])
        );
    end

    // ---------------- P0: undo the quadrant fold ----------------
    logic p0_vld_reg, p0_op_reg;
    logic signed [XW-1:0] ct_reg, st_reg, ca0_reg, sa0_reg;

    // ---------------- P1: radius products ----------------
    logic p1_vld_reg, p1_op_reg;
    logic signed [P1W-1:0] pu_reg, pv_reg;
    logic signed [XW-1:0]  ca1_reg, sa1_reg;

    // ---------------- P2: round to Q16, negate for derivative ----------------
    logic p2_vld_reg, p2_op_reg;
    logic signed [UW-1:0]  ux_reg, uy_reg;
    logic signed [XW-1:0]  ca2_reg, sa2_reg;
    logic signed [P1W-1:0] ru_sum, rv_sum;
    logic signed [UW-1:0]  ux_next;

    // ---------------- P3: tilt products ----------------
    logic p3_vld_reg, p3_op_reg;
    logic signed [P3W-1:0] pxc_reg, pys_reg, pxs_reg, pyc_reg;

    // ---------------- P4: round and combine ----------------
    logic p4_vld_reg, p4_op_reg;
    logic signed [SW-1:0] rx_reg, ry_reg;
    logic signed [P3W-1:0] r_xc, r_ys, r_xs, r_yc;

    // ---------------- output ----------------
    logic signed [SW-1:0] sx, sy, qx, qy;
    logic signed [COORD_BITS-1:0] out_x_reg, out_y_reg;
    logic curve_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_vld_reg   <= 1'b0;
            p1_vld_reg   <= 1'b0;
            p2_vld_reg   <= 1'b0;
            p3_vld_reg   <= 1'b0;
            p4_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            p0_vld_reg   <= vld_reg[N];
            p1_vld_reg   <= p0_vld_reg;
            p2_vld_reg   <= p1_vld_reg;
            p3_vld_reg   <= p2_vld_reg;
            p4_vld_reg   <= p3_vld_reg;
            m_tvalid_reg <= p4_vld_reg;
        end
    end

    always_comb begin
        ru_sum  = pu_reg + HALF1;
        rv_sum  = pv_reg + HALF1;
        ux_next = UW'(ru_sum >>> 30);
        r_xc = (pxc_reg + HALF3) >>> 30;
        r_ys = (pys_reg + HALF3) >>> 30;
        r_xs = (pxs_reg + HALF3) >>> 30;
        r_yc = (pyc_reg + HALF3) >>> 30;
        // center is added for points only
        sx = rx_reg + (p4_op_reg ? SW'(0) : SW'(center_x_reg));
        sy = ry_reg + (p4_op_reg ? SW'(0) : SW'(center_y_reg));
        qx = (sx > SAT_HI) ? SAT_HI : ((sx < SAT_LO) ? SAT_LO : sx);
        qy = (sy > SAT_HI) ? SAT_HI : ((sy < SAT_LO) ? SAT_LO : sy);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p0_op_reg <= op_reg[N];
            ct_reg    <= flip_t_reg[N] ? -xt_w[N] : xt_w[N];
            st_reg    <= flip_t_reg[N] ? -yt_w[N] : yt_w[N];
            ca0_reg   <= flip_a_reg[N] ? -xa_w[N] : xa_w[N];
            sa0_reg   <= flip_a_reg[N] ? -ya_w[N] : ya_w[N];

            p1_op_reg <= p0_op_reg;
            pu_reg    <= $signed({1'b0, radius_one_reg}) * (p0_op_reg ? st_reg : ct_reg);
            pv_reg    <= $signed({1'b0, radius_two_reg}) * (p0_op_reg ? ct_reg : st_reg);
            ca1_reg   <= ca0_reg;
            sa1_reg   <= sa0_reg;

            p2_op_reg <= p1_op_reg;
            ux_reg    <= p1_op_reg ? -ux_next : ux_next;
            uy_reg    <= UW'(rv_sum >>> 30);
            ca2_reg   <= ca1_reg;
            sa2_reg   <= sa1_reg;

            p3_op_reg <= p2_op_reg;
            pxc_reg   <= ux_reg * ca2_reg;
            pys_reg   <= uy_reg * sa2_reg;
            pxs_reg   <= ux_reg * sa2_reg;
            pyc_reg   <= uy_reg * ca2_reg;

            p4_op_reg <= p3_op_reg;
            rx_reg    <= SW'(r_xc) - SW'(r_ys);
            ry_reg    <= SW'(r_xs) + SW'(r_yc);

            out_x_reg       <= qx[COORD_BITS-1:0];
            out_y_reg       <= qy[COORD_BITS-1:0];
            curve_valid_reg <= (radius_one_reg != '0) && (radius_two_reg != '0);
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = OUT_W'({out_y_reg, out_x_reg});
    assign m_tuser[0] = curve_valid_reg;

    // ---------------- assertions ----------------
`include "rotated_ellipse_point_eval_unit_assert.svh"

    `REEP_ASSERT_NEXT(a_stall_holds_pipe, aclk, aresetn, !adv, $stable(p4_vld_reg) && $stable(vld_reg[0]))
    `REEP_ASSERT_NEXT(a_chain_feeds_p0, aclk, aresetn, adv && vld_reg[N], p0_vld_reg)
    `REEP_ASSERT_IMPL(a_cordic_in_range, aclk, aresetn, p0_vld_reg, (ct_reg < CORDIC_LIMIT) && (ct_reg > -CORDIC_LIMIT) && (st_reg < CORDIC_LIMIT) && (st_reg > -CORDIC_LIMIT))
    `REEP_ASSERT_IMPL(a_zero_radius_point, aclk, aresetn, p4_vld_reg && !p4_op_reg && (radius_one_reg == '0) && (radius_two_reg == '0), (rx_reg == '0) && (ry_reg == '0))

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for rotated_ellipse_point_eval_unit: directed and random
// parameter angles over several ellipse settings, each result checked against the bench's predictor.
// Depends on reep_pkg and the unit under test only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import reep_pkg::*;

    localparam int  LATENCY   = DEF_CORDIC_STAGES + 7;
    localparam int  STALL_MAX = 5000;    // cycles without any transfer before giving up
    localparam int  N_PHASES  = 8;
    localparam int  N_RANDOM  = 34;      // random items per phase, after the table
    localparam logic OP_POINT = 1'b0;
    localparam logic OP_DERIV = 1'b1;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               valid;
    } point_t;

    typedef struct packed {
        logic        op;
        logic [15:0] angle;
    } stim_t;

    // directed rows: quadrant edges, wrap-around and both operations
    localparam int N_TABLE = 20;
    localparam stim_t ANGLE_TABLE [N_TABLE] = '{
        '{OP_POINT, 16'h0000}, '{OP_DERIV, 16'h0000},
        '{OP_POINT, 16'h4000}, '{OP_DERIV, 16'h4000},
        '{OP_POINT, 16'h8000}, '{OP_DERIV, 16'h8000},
        '{OP_POINT, 16'hC000}, '{OP_DERIV, 16'hC000},
        '{OP_POINT, 16'hFFFF}, '{OP_DERIV, 16'hFFFF},
        '{OP_POINT, 16'h3FFF}, '{OP_DERIV, 16'h7FFF},
        '{OP_POINT, 16'h4001}, '{OP_DERIV, 16'hBFFF},
        '{OP_POINT, 16'h2000}, '{OP_DERIV, 16'h6000},
        '{OP_POINT, 16'hA000}, '{OP_DERIV, 16'hE000},
        '{OP_POINT, 16'h0001}, '{OP_DERIV, 16'h5555}
    };

    logic        aclk = 1'b0;
    logic        aresetn;
    logic [15:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [31:0] cfg_data;

    always #4 aclk = ~aclk;

    rotated_ellipse_point_eval_unit dut (.*);

    // predictor copy of the configuration
    logic signed [31:0] ctr_x, ctr_y;
    logic [30:0]        rad_one, rad_two;
    logic [15:0]        tilt;

    point_t pending_points[$];
    int     n_errors   = 0;
    int     n_in       = 0;
    int     n_out      = 0;
    int     n_sat      = 0;
    bit     no_idle    = 1'b0;
    bit     track_idle = 1'b0;

    // fixed-length CORDIC over a 16-bit turn fraction, Q2.30 outputs
    function automatic void cordic_sincos(input logic [15:0] a, output longint c,
                                          output longint s);
        logic [31:0] ang;
        logic        flip;
        longint      x, y, z, dx, dy;
        ang  = {a, 16'h0000};
        flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
        if (flip) ang = ang + 32'h8000_0000;
        z = longint'(signed'(ang));
        x = CORDIC_X0;
        y = 0;
        for (int i = 0; i < DEF_CORDIC_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // Q16 times Q30, rounded half up back to Q16; 96 bits keep it exact
    function automatic longint mul_round(input longint a, input longint b);
        logic signed [95:0] pa, pb, p;
        pa = a;
        pb = b;
        p  = pa * pb + (96'sd1 <<< 29);
        return longint'(p >>> 30);
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic point_t ellipse_point(input logic op, input logic [15:0] t);
        longint ct, st, ca, sa, ux, uy, rx, ry;
        point_t p;
        cordic_sincos(t, ct, st);
        cordic_sincos(tilt, ca, sa);
        if (op == OP_DERIV) begin
            ux = -mul_round(longint'(rad_one), st);
            uy = mul_round(longint'(rad_two), ct);
        end else begin
            ux = mul_round(longint'(rad_one), ct);
            uy = mul_round(longint'(rad_two), st);
        end
        rx = mul_round(ux, ca) - mul_round(uy, sa);
        ry = mul_round(ux, sa) + mul_round(uy, ca);
        if (op == OP_POINT) begin
            rx += longint'(ctr_x);
            ry += longint'(ctr_y);
        end
        p.x     = clamp32(rx);
        p.y     = clamp32(ry);
        p.valid = (rad_one != 0) && (rad_two != 0);
        return p;
    endfunction

    // Hold one config write until it transfers, then mirror it in the predictor.
    // Valid stays high for the next write; the caller drops it at the end.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data);
        logic rdy;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do begin
            @(negedge aclk);
            rdy = cfg_ready;
            @(posedge aclk);
        end while (!rdy);
        case (idx)
            CFG_CENTER_X:   ctr_x   = data;
            CFG_CENTER_Y:   ctr_y   = data;
            CFG_RADIUS_ONE: rad_one = data[30:0];
            CFG_RADIUS_TWO: rad_two = data[30:0];
            CFG_TILT_ANGLE: tilt    = data[15:0];
            default: ;
        endcase
    endtask

    // Write all five registers, pad the upper ignored bits with noise, and poke
    // every unused index with data that must be dropped.
    task automatic load_ellipse(input logic [31:0] cx, input logic [31:0] cy,
                                input logic [30:0] r1, input logic [30:0] r2,
                                input logic [15:0] ta);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_RADIUS_ONE, {1'($urandom), r1});
        write_reg(CFG_RADIUS_TWO, {1'($urandom), r2});
        write_reg(CFG_TILT_ANGLE, {16'($urandom), ta});
        for (int k = int'(CFG_TILT_ANGLE) + 1; k < (1 << CFG_IDX_BITS); k++)
            write_reg(k[CFG_IDX_BITS-1:0], $urandom);
        cfg_valid <= 1'b0;
    endtask

    // Present one parameter, wait for its transfer, queue the expected result.
    task automatic send_angle(input logic op, input logic [15:0] t, input bit fixed_zero);
        logic   rdy;
        point_t p;
        s_tvalid <= 1'b1;
        s_tdata  <= t;
        s_tuser  <= op;
        do begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
        end while (!rdy);
        // straight after reset the radii and center are zero: the origin, flagged invalid
        p = fixed_zero ? '{x: 32'sd0, y: 32'sd0, valid: 1'b0} : ellipse_point(op, t);
        pending_points.push_back(p);
        n_in++;
        if (!no_idle && $urandom_range(0, 99) < 25) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
    endtask

    // Drop valid and wait until the pipe is empty before touching registers.
    task automatic drain_pipe;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending_points.size() == 0);
        repeat (LATENCY) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_angle;
        case ($urandom_range(0, 7))
            0:       return {2'($urandom_range(0, 3)), 14'h0000};
            1:       return {2'($urandom_range(0, 3)), 14'h3FFF};
            default: return 16'($urandom);
        endcase
    endfunction

    // result side: random back-pressure, none while a no-idle stretch runs
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(0, 99) >= 25);
        end
    end

    // Sample at the falling edge: whatever is seen here transfers at the next rising edge.
    int stall_cycles = 0;
    always @(negedge aclk) begin
        point_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_out++;
            if (pending_points.size() == 0) begin
                $error("result with no expectation: x=%0d y=%0d",
                       $signed(m_tdata[31:0]), $signed(m_tdata[63:32]));
                n_errors++;
            end else begin
                want = pending_points.pop_front();
                if (m_tdata[31:0] !== want.x) begin
                    $error("out_x: expected %0d, got %0d", want.x, $signed(m_tdata[31:0]));
                    n_errors++;
                end
                if (m_tdata[63:32] !== want.y) begin
                    $error("out_y: expected %0d, got %0d", want.y, $signed(m_tdata[63:32]));
                    n_errors++;
                end
                if (m_tuser[0] !== want.valid) begin
                    $error("curve_valid: expected %0d, got %0d", want.valid, m_tuser[0]);
                    n_errors++;
                end
                if (want.x == 32'sh7FFF_FFFF || want.x == 32'sh8000_0000 ||
                    want.y == 32'sh7FFF_FFFF || want.y == 32'sh8000_0000)
                    n_sat++;
            end
        end
        // watchdog: count consecutive cycles with no transfer on any channel
        if (track_idle && !((m_tvalid && m_tready) || (s_tvalid && s_tready)
                            || (cfg_valid && cfg_ready)))
            stall_cycles++;
        else
            stall_cycles = 0;
        if (stall_cycles >= STALL_MAX) begin
            $display("timeout: %0d cycles without a transfer", STALL_MAX);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        ctr_x = 0; ctr_y = 0; rad_one = 0; rad_two = 0; tilt = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        track_idle = 1'b1;

        // reset values: everything lands on the origin, flagged invalid
        foreach (ANGLE_TABLE[i]) send_angle(ANGLE_TABLE[i].op, ANGLE_TABLE[i].angle, 1'b1);

        for (int ph = 1; ph < N_PHASES; ph++) begin
            drain_pipe();
            case (ph)
                1: load_ellipse(32'h0000_0000, 32'h0000_0000, 31'h0001_0000,
                                31'h0002_0000, 16'h0000);
                // largest radii with extreme centers can drive both outputs into saturation
                2: load_ellipse(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF,
                                31'h7FFF_FFFF, 16'h2000);
                3: load_ellipse(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                                31'h0000_0000, 16'hFFFF);
                4: load_ellipse($urandom, $urandom, 31'h0000_0000,
                                31'h7FFF_FFFF, 16'h8000);
                default: load_ellipse($urandom, $urandom, 31'($urandom),
                                      31'($urandom_range(1, 32'h00FF_FFFF)), 16'($urandom));
            endcase
            no_idle = (ph == 5);
            foreach (ANGLE_TABLE[i]) send_angle(ANGLE_TABLE[i].op, ANGLE_TABLE[i].angle, 1'b0);
            for (int n = 0; n < N_RANDOM; n++) send_angle(1'($urandom), pick_angle(), 1'b0);
            no_idle = 1'b0;
        end

        s_tvalid <= 1'b0;
        wait (pending_points.size() == 0);
        repeat (LATENCY + 5) @(posedge aclk);
        $display("covered %0d parameters over %0d ellipse settings, %0d results checked",
                 n_in, N_PHASES, n_out);
        $display("%0d results hit the saturation limit", n_sat);
        if (n_errors == 0 && pending_points.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/reep_pkg.sv
sv/reep_cordic_cell.sv
sv/rotated_ellipse_point_eval_unit.sv
test/tb.sv
